// ----- rtl/okset_pkg.sv -----
// Shared types and constants for the ordered key set.
package okset_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int KIND_W   = 3;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int GRP      = 32;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_INS  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MEM  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SUCC = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PRED = 3'd4;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                    cmp;
        logic                    ins;
        logic                    del;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

    // reduced search results
    typedef struct packed {
        logic                    present;
        logic                    pred_found;
        logic signed [KEY_W-1:0] pred_key;
        logic                    succ_found;
        logic signed [KEY_W-1:0] succ_key;
    } t_red;

endpackage

// ----- rtl/okset_cell.sv -----
// One cell of the sorted chain: holds a key, compares it, shifts with its neighbors.
module okset_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  okset_pkg::t_cell_ctl             i_ctl,
    input  logic                             i_occ,
    input  logic                             i_left_lt,
    input  logic                             i_left_gt,
    input  logic                             i_right_lt,
    input  logic signed [okset_pkg::KEY_W-1:0] i_left_key,
    input  logic signed [okset_pkg::KEY_W-1:0] i_right_key,
    output logic                             o_lt,
    output logic                             o_gt,
    output logic                             o_eq,
    output logic signed [okset_pkg::KEY_W-1:0] o_key,
    output logic                             o_pred_sel,
    output logic                             o_succ_sel,
    output logic signed [okset_pkg::KEY_W-1:0] o_pred_key,
    output logic signed [okset_pkg::KEY_W-1:0] o_succ_key
);
    import okset_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic                    r_lt;
    logic                    r_gt;
    logic                    r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_gt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_lt <= i_occ && (r_key < i_ctl.key);
            r_gt <= i_occ && (r_key > i_ctl.key);
            r_eq <= i_occ && (r_key == i_ctl.key);
        end
    end

    // insert: cells at or above the slot shift up; delete: they pull from the right
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_left_lt ? i_ctl.key : i_left_key;
        end else if (i_ctl.del && !r_lt) begin
            r_key <= i_right_key;
        end
    end

    assign o_lt       = r_lt;
    assign o_gt       = r_gt;
    assign o_eq       = r_eq;
    assign o_key      = r_key;
    assign o_pred_sel = r_lt && !i_right_lt;
    assign o_succ_sel = r_gt && !i_left_gt;
    assign o_pred_key = o_pred_sel ? r_key : '0;
    assign o_succ_key = o_succ_sel ? r_key : '0;

endmodule

// ----- rtl/okset_reduce.sv -----
// Two-stage registered OR tree that collects match flags and selected keys.
module okset_reduce (
    input  logic                               i_clk,
    input  logic [okset_pkg::CAPACITY-1:0]     i_eq,
    input  logic [okset_pkg::CAPACITY-1:0]     i_pred_sel,
    input  logic [okset_pkg::CAPACITY-1:0]     i_succ_sel,
    input  logic signed [okset_pkg::KEY_W-1:0] i_pred_key [okset_pkg::CAPACITY],
    input  logic signed [okset_pkg::KEY_W-1:0] i_succ_key [okset_pkg::CAPACITY],
    output okset_pkg::t_red                    o_red
);
    import okset_pkg::*;

    t_red r_grp [NGRP];
    t_red n_grp [NGRP];
    t_red r_red;
    t_red n_red;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < CAPACITY) begin
                    n_grp[g].present    |= i_eq[g * GRP + j];
                    n_grp[g].pred_found |= i_pred_sel[g * GRP + j];
                    n_grp[g].succ_found |= i_succ_sel[g * GRP + j];
                    n_grp[g].pred_key   |= i_pred_key[g * GRP + j];
                    n_grp[g].succ_key   |= i_succ_key[g * GRP + j];
                end
            end
        end
    end

    always_comb begin
        n_red = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_red.present    |= r_grp[g].present;
            n_red.pred_found |= r_grp[g].pred_found;
            n_red.succ_found |= r_grp[g].succ_found;
            n_red.pred_key   |= r_grp[g].pred_key;
            n_red.succ_key   |= r_grp[g].succ_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_red <= n_red;
    end

    assign o_red = r_red;

endmodule

// ----- rtl/ordered_key_set.sv -----
// Top level: sorted set of signed keys held in a shifting chain of cells.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tdata: key[31:0]; tuser: kind[2:0]
//  m       | out | o_m_tvalid/i_m_tready  | tdata: found, answer_key, dropped
//
// One item at a time goes through accept, compare in every cell, two levels of the
// OR tree over the cells, then the shift/update that also loads the result.
// The update waits while the output register still holds an untaken result.
// Reset (synchronous, active low) empties the set; cell keys hold no reset value.
module ordered_key_set (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [okset_pkg::S_DATA_W-1:0]    i_s_tdata,  // key[31:0]
    input  logic [okset_pkg::KIND_W-1:0]      i_s_tuser,  // kind[2:0]
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [okset_pkg::M_DATA_W-1:0]    o_m_tdata   // found[0], answer_key[32:1],
                                                          // dropped[33], zero pad
);
    import okset_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_RED1 = 5'b00100,
        S_RED2 = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [KIND_W-1:0]       r_kind;
    logic signed [KEY_W-1:0] r_key;
    logic [OCC_W-1:0]        r_occupancy;
    logic [OCC_W-1:0]        n_occupancy;
    logic                    r_out_valid;
    logic [M_DATA_W-1:0]     r_out_data;
    logic [M_DATA_W-1:0]     n_out_data;

    t_cell_ctl               w_ctl;
    t_red                    w_red;
    logic                    w_full;
    logic                    w_upd;
    logic                    w_found;
    logic signed [KEY_W-1:0] w_answer;
    logic                    w_dropped;
    logic                    w_do_ins;
    logic                    w_do_del;

    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_gt;
    logic [CAPACITY-1:0]     w_eq;
    logic [CAPACITY-1:0]     w_pred_sel;
    logic [CAPACITY-1:0]     w_succ_sel;
    logic signed [KEY_W-1:0] w_key      [CAPACITY];
    logic signed [KEY_W-1:0] w_pred_key [CAPACITY];
    logic signed [KEY_W-1:0] w_succ_key [CAPACITY];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_full     = (r_occupancy == OCC_W'(CAPACITY));
    assign w_upd      = (r_state == S_UPD) && (!r_out_valid || i_m_tready);

    always_comb begin
        w_found   = 1'b0;
        w_answer  = '0;
        w_dropped = 1'b0;
        w_do_ins  = 1'b0;
        w_do_del  = 1'b0;
        unique case (r_kind)
            KIND_INS: begin
                w_found   = w_red.present;
                w_dropped = !w_red.present && w_full;
                w_do_ins  = !w_red.present && !w_full;
            end
            KIND_DEL: begin
                w_found  = w_red.present;
                w_do_del = w_red.present;
            end
            KIND_MEM: begin
                w_found = w_red.present;
            end
            KIND_SUCC: begin
                w_found  = w_red.succ_found;
                w_answer = w_red.succ_key;
            end
            KIND_PRED: begin
                w_found  = w_red.pred_found;
                w_answer = w_red.pred_key;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.ins = w_upd && w_do_ins;
        w_ctl.del = w_upd && w_do_del;
        w_ctl.key = r_key;
    end

    always_comb begin
        n_occupancy = r_occupancy;
        if (w_ctl.ins) begin
            n_occupancy = r_occupancy + OCC_W'(1);
        end else if (w_ctl.del) begin
            n_occupancy = r_occupancy - OCC_W'(1);
        end
        n_out_data = {{(M_DATA_W - KEY_W - 2){1'b0}}, w_dropped, w_answer, w_found};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:  n_state = S_RED1;
            S_RED1: n_state = S_RED2;
            S_RED2: n_state = S_UPD;
            S_UPD: begin
                if (w_upd) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occupancy <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occupancy <= n_occupancy;
            if (w_upd) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_kind <= i_s_tuser;
            r_key  <= i_s_tdata[KEY_W-1:0];
        end
        if (w_upd) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                    w_left_lt;
        logic                    w_left_gt;
        logic                    w_right_lt;
        logic signed [KEY_W-1:0] w_left_key;
        logic signed [KEY_W-1:0] w_right_key;

        if (i == 0) begin : g_first
            // the head cell takes the new key whenever it is at or above the slot
            assign w_left_lt  = 1'b1;
            assign w_left_gt  = 1'b0;
            assign w_left_key = r_key;
        end else begin : g_mid
            assign w_left_lt  = w_lt[i-1];
            assign w_left_gt  = w_gt[i-1];
            assign w_left_key = w_key[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right_lt  = 1'b0;
            assign w_right_key = w_key[i];
        end else begin : g_inner
            assign w_right_lt  = w_lt[i+1];
            assign w_right_key = w_key[i+1];
        end

        okset_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_occ       (r_occupancy > OCC_W'(i)),
            .i_left_lt   (w_left_lt),
            .i_left_gt   (w_left_gt),
            .i_right_lt  (w_right_lt),
            .i_left_key  (w_left_key),
            .i_right_key (w_right_key),
            .o_lt        (w_lt[i]),
            .o_gt        (w_gt[i]),
            .o_eq        (w_eq[i]),
            .o_key       (w_key[i]),
            .o_pred_sel  (w_pred_sel[i]),
            .o_succ_sel  (w_succ_sel[i]),
            .o_pred_key  (w_pred_key[i]),
            .o_succ_key  (w_succ_key[i])
        );
    end

    okset_reduce u_reduce (
        .i_clk      (i_clk),
        .i_eq       (w_eq),
        .i_pred_sel (w_pred_sel),
        .i_succ_sel (w_succ_sel),
        .i_pred_key (w_pred_key),
        .i_succ_key (w_succ_key),
        .o_red      (w_red)
    );

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occupancy <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

    a_occ_only_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_upd |=> $stable(r_occupancy))
        else $error("occupancy changed outside update");

    a_drop_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[KEY_W+1]) |-> !o_m_tdata[0])
        else $error("dropped insert reported as found");

    a_ins_del_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ins && w_ctl.del))
        else $error("insert and delete in the same cycle");
`endif

endmodule

// ----- tb/sv/ordered_key_set_test.sv -----
// Testbench for ordered_key_set: directed table, then random requests checked against a set model.
`timescale 1ns / 1ps

module ordered_key_set_test;
    import okset_pkg::*;

    // kinds the block must treat as no-ops
    localparam logic [KIND_W-1:0] KIND_RSV5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSV6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSV7 = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    localparam int N_DIR    = 24;
    localparam int N_PHASE  = 4;
    localparam int PHASE_SZ = 194;
    localparam int POOL_SZ  = 64;

    typedef struct packed {
        logic                    found;
        logic signed [KEY_W-1:0] answer_key;
        logic                    dropped;
    } t_reply;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        logic                    typed;   // reply below is the expectation
        t_reply                  reply;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata;     // key[31:0]
    logic [KIND_W-1:0]     i_s_tuser;     // kind[2:0]
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b1;
    logic [M_DATA_W-1:0]   o_m_tdata;     // found[0], answer_key[32:1], dropped[33], zero pad

    ordered_key_set dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    logic signed [KEY_W-1:0] stored_keys [$];   // model of the set, ascending
    t_reply                  pending_replies [$];
    logic signed [KEY_W-1:0] key_pool [POOL_SZ];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_errors = 0;
    int n_requests = 0;
    int n_replies = 0;
    int n_drops = 0;
    int peak_occ = 0;

    t_dir_row dir_rows [N_DIR] = '{
        '{KIND_MEM,  32'sd0,       1'b1, '{1'b0, 32'sd0, 1'b0}},  // empty after reset
        '{KIND_SUCC, KEY_MIN,      1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_PRED, KEY_MAX,      1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_DEL,  32'sd5,       1'b1, '{1'b0, 32'sd0, 1'b0}},  // delete absent
        '{KIND_INS,  KEY_MIN,      1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_INS,  KEY_MAX,      1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_INS,  32'sd0,       1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_INS,  32'sd0,       1'b1, '{1'b1, 32'sd0, 1'b0}},  // duplicate insert
        '{KIND_SUCC, KEY_MIN,      1'b1, '{1'b1, 32'sd0, 1'b0}},
        '{KIND_PRED, KEY_MAX,      1'b1, '{1'b1, 32'sd0, 1'b0}},
        '{KIND_SUCC, KEY_MAX,      1'b1, '{1'b0, 32'sd0, 1'b0}},  // nothing above max
        '{KIND_PRED, KEY_MIN,      1'b1, '{1'b0, 32'sd0, 1'b0}},  // nothing below min
        '{KIND_SUCC, -32'sd1,      1'b0, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_PRED, 32'sd1,       1'b0, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_MEM,  KEY_MAX,      1'b1, '{1'b1, 32'sd0, 1'b0}},
        '{KIND_RSV5, 32'sd0,       1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_RSV6, -32'sd1,      1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_RSV7, KEY_MAX,      1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_DEL,  32'sd0,       1'b1, '{1'b1, 32'sd0, 1'b0}},
        '{KIND_DEL,  32'sd0,       1'b1, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_SUCC, KEY_MIN,      1'b0, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_PRED, KEY_MAX,      1'b0, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_MEM,  32'sh5555_5555, 1'b0, '{1'b0, 32'sd0, 1'b0}},
        '{KIND_INS,  32'sh2AAA_AAAA, 1'b0, '{1'b0, 32'sd0, 1'b0}}
    };

    // Applies one request to the set model and returns the reply it must produce.
    function automatic t_reply apply_to_set(input logic [KIND_W-1:0] kind,
                                            input logic signed [KEY_W-1:0] key);
        t_reply r;
        int     pos;
        int     nxt;
        bit     present;
        r = '0;
        pos = 0;
        while (pos < stored_keys.size() && stored_keys[pos] < key)
            pos++;
        present = (pos < stored_keys.size()) && (stored_keys[pos] == key);
        case (kind)
            KIND_INS: begin
                if (present) begin
                    r.found = 1'b1;
                end else if (stored_keys.size() >= CAPACITY) begin
                    r.dropped = 1'b1;
                end else begin
                    stored_keys.insert(pos, key);
                end
            end
            KIND_DEL: begin
                if (present) begin
                    r.found = 1'b1;
                    stored_keys.delete(pos);
                end
            end
            KIND_MEM: r.found = present;
            KIND_SUCC: begin
                nxt = present ? pos + 1 : pos;
                if (nxt < stored_keys.size()) begin
                    r.found = 1'b1;
                    r.answer_key = stored_keys[nxt];
                end
            end
            KIND_PRED: begin
                if (pos > 0) begin
                    r.found = 1'b1;
                    r.answer_key = stored_keys[pos-1];
                end
            end
            default: ;
        endcase
        if (stored_keys.size() > peak_occ)
            peak_occ = stored_keys.size();
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [KEY_W-1:0] key,
                                input logic typed, input t_reply typed_reply);
        t_reply want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = key;
        i_s_tuser  = kind;
        do @(posedge i_clk); while (!o_s_tready);
        want = apply_to_set(kind, key);
        if (typed)
            want = typed_reply;
        pending_replies.push_back(want);
        n_requests++;
        @(negedge i_clk);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return KIND_INS;
        if (r < 50) return KIND_DEL;
        if (r < 65) return KIND_MEM;
        if (r < 80) return KIND_SUCC;
        if (r < 95) return KIND_PRED;
        case ($urandom_range(2))
            0:       return KIND_RSV5;
            1:       return KIND_RSV6;
            default: return KIND_RSV7;
        endcase
    endfunction

    always @(negedge i_clk)
        i_m_tready = ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin : check_replies
        t_reply got;
        t_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.found      = o_m_tdata[0];
            got.answer_key = o_m_tdata[32:1];
            got.dropped    = o_m_tdata[33];
            n_replies++;
            if (got.dropped)
                n_drops++;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result item found=%0b answer_key=%0d dropped=%0b",
                         $realtime, got.found, got.answer_key, got.dropped);
                n_errors++;
            end else begin
                want = pending_replies.pop_front();
                if (got.found !== want.found) begin
                    $display("%0t: found mismatch: expected %0b, got %0b",
                             $realtime, want.found, got.found);
                    n_errors++;
                end
                if (got.answer_key !== want.answer_key) begin
                    $display("%0t: answer_key mismatch: expected %0d, got %0d",
                             $realtime, want.answer_key, got.answer_key);
                    n_errors++;
                end
                if (got.dropped !== want.dropped) begin
                    $display("%0t: dropped mismatch: expected %0b, got %0b",
                             $realtime, want.dropped, got.dropped);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d result items outstanding", pending_replies.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int                      send_pct [N_PHASE] = '{0, 62, 0, 33};
        int                      recv_pct [N_PHASE] = '{0, 0, 62, 33};
        logic signed [KEY_W-1:0] key;
        logic [KIND_W-1:0]       kind;
        int                      guard;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SZ; i++)
            key_pool[i] = $urandom;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed,
                         dir_rows[i].reply);

        // mixed traffic over a small key pool so hits and neighbors are common
        for (int ph = 0; ph < N_PHASE; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (int n = 0; n < PHASE_SZ; n++) begin
                kind = pick_kind();
                key  = ($urandom_range(3) != 0) ? key_pool[$urandom_range(POOL_SZ-1)]
                                                : $urandom;
                send_request(kind, key, 1'b0, '0);
            end
        end
        i_s_tvalid     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        guard = 0;
        while (pending_replies.size() != 0 && guard < 100_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            $display("%0t: %0d expected result items never arrived",
                     $realtime, pending_replies.size());
            n_errors++;
        end

        $display("Sent %0d requests, checked %0d results (%0d inserts dropped when full).",
                 n_requests, n_replies, n_drops);
        $display("Set occupancy peaked at %0d of %0d entries.", peak_occ, CAPACITY);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
